@@ sv/pupd_pkg.sv @@
// Shared types, codes and constants of the priority update frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pupd_pkg;

  // Widths of the frame fields
  localparam int unsigned VARINT_W   = 62;
  localparam int unsigned CONSUMED_W = 63;

  // Result queue depth and its pointer and level widths
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Reject reasons
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd2;
  localparam logic [1:0] ERR_OVERRUN   = 2'd3;

  // Configuration register indexes
  localparam logic REG_REQUEST_TYPE = 1'b0;
  localparam logic REG_PUSH_TYPE    = 1'b1;

  // Configuration reset values
  localparam logic [VARINT_W-1:0] REQUEST_TYPE_RESET = 62'd983808;
  localparam logic [VARINT_W-1:0] PUSH_TYPE_RESET    = 62'd983809;

  // One input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]            result_kind;
    logic [7:0]            value_byte;
    logic                  is_push;
    logic [VARINT_W-1:0]   prio_id;
    logic [VARINT_W-1:0]   value_length;
    logic [CONSUMED_W-1:0] consumed_length;
    logic [1:0]            error_code;
    logic                  last;
  } res_t;

  // Configuration register contents
  typedef struct packed {
    logic [VARINT_W-1:0] request_code;
    logic [VARINT_W-1:0] push_code;
  } cfg_t;

  // Results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  // Result queue status
  typedef struct packed {
    logic [FIFO_LVL_W-1:0] level;
    logic                  nearly_full;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ sv/pupd_cfg.sv @@
// Configuration registers: frame type codes of the two priority update variants.
// Depends on pupd_pkg.
`default_nettype none

module pupd_cfg
  import pupd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [VARINT_W-1:0] cfg_data,
  output cfg_t                     cfg
);

  // Decode the index and load the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_code <= REQUEST_TYPE_RESET;
      cfg.push_code    <= PUSH_TYPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REQUEST_TYPE: cfg.request_code <= cfg_data;
        REG_PUSH_TYPE:    cfg.push_code    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/pupd_parser.sv @@
// Byte-wide frame parser: varint decode, type match, body tracking, results.
// Depends on pupd_pkg.
`default_nettype none

module pupd_parser
  import pupd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  input  wire in_t  in_item,
  input  wire cfg_t cfg,
  output push_t     push
);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_ID,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  phase_t                phase, phase_next;
  logic [VARINT_W-1:0]   acc, acc_next;
  logic [2:0]            vleft, vleft_next;
  logic                  push_seen, push_seen_next;
  logic                  type_ok, type_ok_next;
  logic [VARINT_W-1:0]   body_left, body_left_next;
  logic [VARINT_W-1:0]   value_count, value_count_next;
  logic [CONSUMED_W-1:0] consumed, consumed_next;
  logic [VARINT_W-1:0]   id_held, id_held_next;

  logic [VARINT_W-1:0] feed_acc;
  logic [2:0]          feed_left;
  logic                feed_done;
  logic [VARINT_W-1:0] body_dec;
  logic                done;
  logic                accept;
  logic                has_value;
  logic [1:0]          err;
  res_t                value_res;
  res_t                fin_res;

  // Feed the byte into the current varint
  always_comb begin
    if (vleft == 3'd0) begin
      feed_acc = {56'd0, in_item.in_byte[5:0]};
      case (in_item.in_byte[7:6])
        2'd0:    feed_left = 3'd0;
        2'd1:    feed_left = 3'd1;
        2'd2:    feed_left = 3'd3;
        default: feed_left = 3'd7;
      endcase
    end else begin
      feed_acc  = {acc[VARINT_W-9:0], in_item.in_byte};
      feed_left = vleft - 3'd1;
    end
    feed_done = (feed_left == 3'd0);
    body_dec  = body_left - VARINT_W'(1);
  end

  // Next state and results for one byte
  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    vleft_next       = vleft;
    push_seen_next   = push_seen;
    type_ok_next     = type_ok;
    body_left_next   = body_left;
    value_count_next = value_count;
    consumed_next    = consumed;
    id_held_next     = id_held;
    done             = 1'b0;
    accept           = 1'b0;
    has_value        = 1'b0;
    err              = ERR_NONE;
    value_res        = '0;
    fin_res          = '0;
    push             = '0;

    if (take) begin
      if (phase != PH_SKIP) begin
        consumed_next = consumed + CONSUMED_W'(1);
      end

      unique case (phase)
        PH_SKIP: begin
          // Drop bytes up to the end of the buffer
          if (in_item.end_of_buffer) begin
            phase_next       = PH_TYPE;
            acc_next         = '0;
            vleft_next       = '0;
            push_seen_next   = 1'b0;
            type_ok_next     = 1'b0;
            body_left_next   = '0;
            value_count_next = '0;
            consumed_next    = '0;
            id_held_next     = '0;
          end
        end
        PH_TYPE: begin
          acc_next   = feed_acc;
          vleft_next = feed_left;
          if (feed_done) begin
            push_seen_next = (feed_acc == cfg.push_code);
            type_ok_next   = (feed_acc == cfg.push_code) || (feed_acc == cfg.request_code);
            phase_next     = PH_LEN;
          end
        end
        PH_LEN: begin
          acc_next   = feed_acc;
          vleft_next = feed_left;
          if (feed_done) begin
            if (!type_ok) begin
              done = 1'b1;
              err  = ERR_UNKNOWN;
            end else if (feed_acc == '0) begin
              done = 1'b1;
              err  = ERR_OVERRUN;
            end else begin
              body_left_next = feed_acc;
              phase_next     = PH_ID;
            end
          end
        end
        PH_ID: begin
          acc_next       = feed_acc;
          vleft_next     = feed_left;
          body_left_next = body_dec;
          if (feed_done) begin
            id_held_next = feed_acc;
            if (body_dec == '0) begin
              done   = 1'b1;
              accept = 1'b1;
            end else begin
              phase_next = PH_VALUE;
            end
          end else if (body_dec == '0) begin
            done = 1'b1;
            err  = ERR_OVERRUN;
          end
        end
        PH_VALUE: begin
          has_value        = 1'b1;
          value_count_next = value_count + VARINT_W'(1);
          body_left_next   = body_dec;
          if (body_dec == '0) begin
            done   = 1'b1;
            accept = 1'b1;
          end
        end
        default: ;
      endcase

      // Cut short by the end of the buffer
      if (phase != PH_SKIP && !done && in_item.end_of_buffer) begin
        done = 1'b1;
        err  = ERR_TRUNCATED;
      end

      // Value byte result
      value_res.result_kind = KIND_VALUE;
      value_res.value_byte  = in_item.in_byte;
      value_res.is_push     = push_seen;
      value_res.prio_id     = id_held;
      value_res.error_code  = ERR_NONE;
      value_res.last        = !done;

      // Accept or reject result
      fin_res.is_push = push_seen_next;
      fin_res.last    = 1'b1;
      if (accept) begin
        fin_res.result_kind     = KIND_ACCEPT;
        fin_res.prio_id         = id_held_next;
        fin_res.value_length    = value_count_next;
        fin_res.consumed_length = consumed_next;
        fin_res.error_code      = ERR_NONE;
      end else begin
        fin_res.result_kind = KIND_REJECT;
        fin_res.error_code  = err;
      end

      // Hand results to the queue in order
      if (has_value) begin
        push.first  = value_res;
        push.second = fin_res;
        push.count  = done ? 2'd2 : 2'd1;
      end else if (done) begin
        push.first = fin_res;
        push.count = 2'd1;
      end

      // Clear the frame once it is finished
      if (done) begin
        phase_next       = in_item.end_of_buffer ? PH_TYPE : PH_SKIP;
        acc_next         = '0;
        vleft_next       = '0;
        push_seen_next   = 1'b0;
        type_ok_next     = 1'b0;
        body_left_next   = '0;
        value_count_next = '0;
        consumed_next    = '0;
        id_held_next     = '0;
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      acc         <= '0;
      vleft       <= '0;
      push_seen   <= 1'b0;
      type_ok     <= 1'b0;
      body_left   <= '0;
      value_count <= '0;
      consumed    <= '0;
      id_held     <= '0;
    end else begin
      phase       <= phase_next;
      acc         <= acc_next;
      vleft       <= vleft_next;
      push_seen   <= push_seen_next;
      type_ok     <= type_ok_next;
      body_left   <= body_left_next;
      value_count <= value_count_next;
      consumed    <= consumed_next;
      id_held     <= id_held_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/pupd_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per cycle while popped.
// Depends on pupd_pkg.
`default_nettype none

module pupd_fifo
  import pupd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output res_t       head,
  output fifo_stat_t stat
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [FIFO_LVL_W-1:0] level, level_next;

  // Advance pointers and level
  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_PTR_W'(push.count);
    rd_ptr_next = rd_ptr + FIFO_PTR_W'(pop);
    level_next  = level + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  assign head             = mem[rd_ptr];
  assign stat.level       = level;
  assign stat.nearly_full = (level >= FIFO_LVL_W'(FIFO_DEPTH - 1));

endmodule

`default_nettype wire

@@ sv/priority_update_frame_parser_core.sv @@
// Priority update frame parser. Takes one frame byte per cycle and returns value
// bytes, then an accept or reject result. An input byte is taken every cycle while
// the four-entry result queue holds fewer than three results; a byte that yields
// two results (the last value byte with its accept, or a value byte with a
// truncation reject) adds a second entry, so a run of such bytes slows to the
// output drain rate of one result per cycle. A result is registered into the queue
// when its byte is taken. Type code registers are written through the cfg port.
// Depends on pupd_pkg, pupd_cfg, pupd_parser and pupd_fifo.
`default_nettype none

module priority_update_frame_parser_core
  import pupd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [VARINT_W-1:0] cfg_data,
  input  wire logic                byte_valid,
  output logic                     byte_stall,
  input  wire in_t                 byte_data,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output res_t                     res_data
);

  cfg_t       cfg;
  push_t      push;
  fifo_stat_t stat;
  logic       take;
  logic       pop;

  // Handshakes
  assign byte_stall = stat.nearly_full;
  assign take       = byte_valid && !byte_stall;
  assign res_valid  = (stat.level != '0);
  assign pop        = res_valid && !res_stall;

  pupd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pupd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_item (byte_data),
    .cfg     (cfg),
    .push    (push)
  );

  pupd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (res_data),
    .stat (stat)
  );

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (stat.level <= FIFO_LVL_W'(FIFO_DEPTH - 2)))
    else $error("result queue overflow");

  // Results only come from taken bytes
  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    !take |-> (push.count == 2'd0))
    else $error("result without a taken byte");

  // Reject results carry a reason and no element id or consumed length
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.result_kind == KIND_REJECT) |->
      (res_data.error_code != ERR_NONE && res_data.prio_id == '0 &&
       res_data.consumed_length == '0))
    else $error("malformed reject transaction");

  // Value and accept results carry no reason
  a_ok_no_error: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.result_kind != KIND_REJECT) |->
      (res_data.error_code == ERR_NONE))
    else $error("error code on a non-reject transaction");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for priority_update_frame_parser_core: byte driver, result monitor
// and an in-bench frame decoder that predicts every value, accept and reject result.
// Depends on pupd_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_top;
  import pupd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 250;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [VARINT_W-1:0] FIELD_MAX = {VARINT_W{1'b1}};

  typedef enum logic [2:0] {
    SEEK_TYPE, READ_LENGTH, READ_ID, COPY_VALUE, SKIP_TAIL
  } tb_phase_t;

  typedef enum int {
    FRAME_GOOD, FRAME_UNKNOWN, FRAME_ZERO_LEN, FRAME_OVERRUN, FRAME_TRUNCATED, FRAME_NOISE
  } frame_shape_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [VARINT_W-1:0] cfg_data = '0;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  in_t                 byte_data = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  res_t                res_data;

  priority_update_frame_parser_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder copy of the type registers and frame state
  logic [VARINT_W-1:0]   request_code = REQUEST_TYPE_RESET;
  logic [VARINT_W-1:0]   push_code = PUSH_TYPE_RESET;
  tb_phase_t             phase = SEEK_TYPE;
  logic [VARINT_W-1:0]   acc;
  logic [2:0]            varint_left;
  logic                  push_seen;
  logic                  type_match;
  logic [VARINT_W-1:0]   body_left;
  logic [VARINT_W-1:0]   value_cnt;
  logic [CONSUMED_W-1:0] consumed_cnt;
  logic [VARINT_W-1:0]   id_held;

  // Bench bookkeeping
  in_t        pending_bytes[$];
  res_t       expected_results[$];
  logic [7:0] frame_bytes[$];
  res_t       want_res;
  int         mismatch_count = 0;
  int         bytes_accepted = 0;
  int         results_seen = 0;
  int         value_results = 0;
  int         accept_count = 0;
  int         reject_count[4] = '{0, 0, 0, 0};
  int         settings_used = 1;
  int         cycle_count = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_cycles = 0;
  bit         hold_done = 1'b0;
  logic       hold_active = 1'b0;
  bit         send_steady = 1'b0;
  bit         recv_steady = 1'b0;
  bit         byte_taken = 1'b0;
  bit         result_taken = 1'b0;

  task automatic clear_frame();
    acc = '0;
    varint_left = '0;
    push_seen = 1'b0;
    type_match = 1'b0;
    body_left = '0;
    value_cnt = '0;
    consumed_cnt = '0;
    id_held = '0;
  endtask

  // Shift one byte into the current varint; true once it is complete
  function automatic logic feed_varint(input logic [7:0] b);
    if (varint_left == 3'd0) begin
      acc = VARINT_W'(b[5:0]);
      varint_left = 3'((4'd1 << b[7:6]) - 4'd1);
    end else begin
      acc = {acc[VARINT_W-9:0], b};
      varint_left = varint_left - 3'd1;
    end
    return varint_left == 3'd0;
  endfunction

  function automatic res_t make_result(input logic [1:0] kind, input logic [7:0] vb,
                                       input logic [VARINT_W-1:0] elem_id,
                                       input logic [VARINT_W-1:0] vlen,
                                       input logic [CONSUMED_W-1:0] cons,
                                       input logic [1:0] err);
    res_t r;
    r.result_kind = kind;
    r.value_byte = vb;
    r.is_push = push_seen;
    r.prio_id = elem_id;
    r.value_length = vlen;
    r.consumed_length = cons;
    r.error_code = err;
    r.last = 1'b0;
    return r;
  endfunction

  // Decode one accepted byte and queue the results it produces
  task automatic parse_byte(input in_t item);
    res_t       outs[$];
    logic       done;
    logic       accept;
    logic       complete;
    logic [1:0] err;
    done = 1'b0;
    accept = 1'b0;
    err = ERR_NONE;
    if (phase == SKIP_TAIL) begin
      if (item.end_of_buffer) begin
        phase = SEEK_TYPE;
        clear_frame();
      end
      return;
    end
    consumed_cnt = consumed_cnt + CONSUMED_W'(1);
    case (phase)
      SEEK_TYPE: begin
        if (feed_varint(item.in_byte)) begin
          push_seen = (acc == push_code);
          type_match = (acc == push_code) || (acc == request_code);
          phase = READ_LENGTH;
        end
      end
      READ_LENGTH: begin
        if (feed_varint(item.in_byte)) begin
          if (!type_match) begin
            done = 1'b1;
            err = ERR_UNKNOWN;
          end else if (acc == '0) begin
            done = 1'b1;
            err = ERR_OVERRUN;
          end else begin
            body_left = acc;
            phase = READ_ID;
          end
        end
      end
      READ_ID: begin
        complete = feed_varint(item.in_byte);
        body_left = body_left - VARINT_W'(1);
        if (complete) begin
          id_held = acc;
          if (body_left == '0) begin
            done = 1'b1;
            accept = 1'b1;
          end else begin
            phase = COPY_VALUE;
          end
        end else if (body_left == '0) begin
          done = 1'b1;
          err = ERR_OVERRUN;
        end
      end
      default: begin
        outs.push_back(make_result(KIND_VALUE, item.in_byte, id_held, '0, '0, ERR_NONE));
        value_results++;
        value_cnt = value_cnt + VARINT_W'(1);
        body_left = body_left - VARINT_W'(1);
        if (body_left == '0) begin
          done = 1'b1;
          accept = 1'b1;
        end
      end
    endcase
    // End of buffer before the frame finished
    if (!done && item.end_of_buffer) begin
      done = 1'b1;
      err = ERR_TRUNCATED;
    end
    if (done) begin
      if (accept) begin
        outs.push_back(make_result(KIND_ACCEPT, 8'h00, id_held, value_cnt, consumed_cnt,
                                   ERR_NONE));
        accept_count++;
      end else begin
        outs.push_back(make_result(KIND_REJECT, 8'h00, '0, '0, '0, err));
        reject_count[err]++;
      end
      clear_frame();
      phase = item.end_of_buffer ? SEEK_TYPE : SKIP_TAIL;
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endtask

  // Frame building
  function automatic int min_bytes(input logic [VARINT_W-1:0] v);
    if (v < 64) return 1;
    if (v < 16384) return 2;
    if (v < (VARINT_W'(1) << 30)) return 4;
    return 8;
  endfunction

  // Shortest encoding, sometimes a longer one
  function automatic int pick_len(input logic [VARINT_W-1:0] v, input int least);
    int n;
    n = min_bytes(v);
    if (n < least) n = least;
    if ($urandom_range(0, 3) == 0) begin
      while (n < 8 && $urandom_range(0, 1) == 1) n = n * 2;
    end
    return n;
  endfunction

  function automatic logic [VARINT_W-1:0] rand_field();
    logic [VARINT_W-1:0] w;
    w = VARINT_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 4))
      0: return VARINT_W'(w[5:0]);
      1: return VARINT_W'(w[13:0]);
      2: return VARINT_W'(w[29:0]);
      3: return w;
      default: return $urandom_range(0, 1) ? FIELD_MAX : '0;
    endcase
  endfunction

  task automatic add_varint(input logic [VARINT_W-1:0] v, input int nbytes);
    logic [63:0] word;
    logic [7:0]  b;
    logic [1:0]  code;
    code = (nbytes == 1) ? 2'd0 : (nbytes == 2) ? 2'd1 : (nbytes == 4) ? 2'd2 : 2'd3;
    word = {2'b00, v};
    for (int i = nbytes - 1; i >= 0; i--) begin
      b = word[8*i +: 8];
      if (i == nbytes - 1) b[7:6] = code;
      frame_bytes.push_back(b);
    end
  endtask

  // Flag the last byte of the buffer and hand it to the driver
  task automatic emit_buffer();
    foreach (frame_bytes[i]) begin
      pending_bytes.push_back(in_t'{in_byte: frame_bytes[i],
                                    end_of_buffer: (i == frame_bytes.size() - 1)});
    end
    frame_bytes.delete();
  endtask

  task automatic queue_buffer(input logic [VARINT_W-1:0] ftype, input int type_len,
                              input logic [VARINT_W-1:0] blen, input int blen_len,
                              input logic [VARINT_W-1:0] elem_id, input int id_len,
                              input int nval, input int cut, input int trailing);
    frame_bytes.delete();
    add_varint(ftype, type_len);
    add_varint(blen, blen_len);
    add_varint(elem_id, id_len);
    repeat (nval) frame_bytes.push_back(8'($urandom));
    if (cut > 0) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    repeat (trailing) frame_bytes.push_back(8'($urandom));
    emit_buffer();
  endtask

  task automatic queue_random_frame();
    frame_shape_t        shape;
    int                  pick;
    int                  nval;
    int                  type_len;
    int                  blen_len;
    int                  id_len;
    int                  cut;
    int                  trailing;
    logic [VARINT_W-1:0] ftype;
    logic [VARINT_W-1:0] elem_id;
    logic [VARINT_W-1:0] blen;
    pick = $urandom_range(0, 99);
    shape = (pick < 58) ? FRAME_GOOD : (pick < 66) ? FRAME_UNKNOWN :
            (pick < 71) ? FRAME_ZERO_LEN : (pick < 80) ? FRAME_OVERRUN :
            (pick < 93) ? FRAME_TRUNCATED : FRAME_NOISE;
    if (shape == FRAME_NOISE) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      emit_buffer();
      return;
    end
    ftype = $urandom_range(0, 1) ? push_code : request_code;
    if (shape == FRAME_UNKNOWN) begin
      do ftype = rand_field(); while (ftype == push_code || ftype == request_code);
    end
    elem_id = rand_field();
    nval = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
    id_len = pick_len(elem_id, (shape == FRAME_OVERRUN) ? 2 : 1);
    case (shape)
      FRAME_ZERO_LEN: blen = '0;
      FRAME_OVERRUN: blen = VARINT_W'($urandom_range(1, id_len - 1));
      default: blen = VARINT_W'(id_len + nval);
    endcase
    type_len = pick_len(ftype, 1);
    blen_len = pick_len(blen, 1);
    if (shape == FRAME_TRUNCATED) begin
      cut = $urandom_range(1, type_len + blen_len + id_len + nval - 1);
      trailing = 0;
    end else begin
      cut = 0;
      trailing = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
    end
    queue_buffer(ftype, type_len, blen, blen_len, elem_id, id_len, nval, cut, trailing);
  endtask

  task automatic fill_random(input int nbytes);
    int target;
    target = pending_bytes.size() + nbytes;
    while (pending_bytes.size() < target) queue_random_frame();
  endtask

  task automatic write_reg(input logic idx, input logic [VARINT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REQUEST_TYPE) request_code = val;
    else push_code = val;
  endtask

  // Drain everything, then let bytes that yield no result clear the pipeline
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at result %0d, %s: got 0x%0h, want 0x%0h",
             results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic int draw_wait(input bit steady);
    if (steady) return 0;
    return $urandom_range(0, 1) ? $urandom_range(0, 18) : 0;
  endfunction

  // Record byte transactions and run the decoder on them
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      byte_taken = 1'b1;
      bytes_accepted++;
      parse_byte(byte_data);
    end
  end

  // Offer the next byte after its drawn gap; go flat out during the hold-off
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      byte_taken = 1'b0;
      if (gap_left > 0 && !hold_active) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        byte_data <= pending_bytes.pop_front();
        byte_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
        gap_left = draw_wait(send_steady);
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      result_taken = 1'b1;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(res_data.result_kind), '0);
      end else begin
        want_res = expected_results.pop_front();
        check_field("result_kind", 64'(res_data.result_kind), 64'(want_res.result_kind));
        check_field("value_byte", 64'(res_data.value_byte), 64'(want_res.value_byte));
        check_field("is_push", 64'(res_data.is_push), 64'(want_res.is_push));
        check_field("prio_id", 64'(res_data.prio_id), 64'(want_res.prio_id));
        check_field("value_length", 64'(res_data.value_length), 64'(want_res.value_length));
        check_field("consumed_length", 64'(res_data.consumed_length),
                    64'(want_res.consumed_length));
        check_field("error_code", 64'(res_data.error_code), 64'(want_res.error_code));
        check_field("last", 64'(res_data.last), 64'(want_res.last));
      end
    end
  end

  // Stall the result side after each transaction, counting down a drawn wait while a result is valid
  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      if ($urandom_range(0, 47) == 0) recv_steady = !recv_steady;
      stall_left = draw_wait(recv_steady);
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      if (res_valid) stall_left--;
    end else begin
      res_stall <= hold_active;
    end
  end

  // Hold off the result side once for a long stretch so the block backs up
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && !hold_active && bytes_accepted >= 150) begin
        hold_active <= 1'b1;
      end else if (hold_active) begin
        hold_cycles++;
        if (hold_cycles >= 300) begin
          hold_active <= 1'b0;
          hold_done = 1'b1;
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: directed frames, then random frames under several register settings
  initial begin
    logic [VARINT_W-1:0] same_code;
    clear_frame();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Good request frame with one value byte; push frame with the widest id
    queue_buffer(request_code, 4, 62'd2, 1, '0, 1, 1, 0, 0);
    queue_buffer(push_code, 8, 62'd8, 1, FIELD_MAX, 8, 0, 0, 0);
    // Unknown type with zero length; known type with zero length
    queue_buffer('0, 1, '0, 1, '0, 1, 0, 0, 0);
    queue_buffer(request_code, 4, '0, 1, 62'd5, 1, 0, 0, 2);
    // Element id longer than the body, then the same with the end flag on the overrun byte
    queue_buffer(request_code, 4, 62'd2, 1, 62'd1000, 4, 0, 0, 0);
    queue_buffer(request_code, 4, 62'd2, 1, 62'd1, 8, 0, 7, 0);
    // Truncated inside the type and inside the value bytes
    queue_buffer(request_code, 4, 62'd3, 1, 62'd7, 1, 2, 1, 0);
    queue_buffer(push_code, 4, 62'd4, 1, 62'd7, 1, 3, 8, 0);
    // Good frame followed by bytes that are skipped up to the end flag
    queue_buffer(request_code, 4, 62'd3, 2, 62'd63, 1, 2, 0, 3);
    // Unknown type cut short inside the length
    queue_buffer(62'd12345, 4, 62'd300, 2, '0, 1, 0, 5, 0);
    // Largest body length, cut short
    queue_buffer(request_code, 4, FIELD_MAX, 8, 62'd9, 1, 5, 18, 0);
    fill_random(PHASE_BYTES);
    wait_idle();

    // Extremes of the type registers
    write_reg(REG_REQUEST_TYPE, '0);
    write_reg(REG_PUSH_TYPE, FIELD_MAX);
    settings_used++;
    fill_random(PHASE_BYTES);
    wait_idle();

    // Equal registers: a match counts as push
    same_code = rand_field();
    write_reg(REG_REQUEST_TYPE, same_code);
    write_reg(REG_PUSH_TYPE, same_code);
    settings_used++;
    fill_random(PHASE_BYTES);
    wait_idle();

    // Codes on the one/two byte encoding boundary
    write_reg(REG_REQUEST_TYPE, 62'd63);
    write_reg(REG_PUSH_TYPE, 62'd64);
    settings_used++;
    fill_random(PHASE_BYTES);
    wait_idle();

    // Arbitrary wide codes
    write_reg(REG_REQUEST_TYPE, VARINT_W'({$urandom(), $urandom()}));
    write_reg(REG_PUSH_TYPE, VARINT_W'({$urandom(), $urandom()}));
    settings_used++;
    fill_random(PHASE_BYTES);
    wait_idle();

    $display("Run: %0d bytes in, %0d results checked under %0d type register settings",
             bytes_accepted, results_seen, settings_used);
    $display("  %0d value bytes, %0d accepts, rejects: %0d truncated, %0d unknown, %0d overrun",
             value_results, accept_count, reject_count[ERR_TRUNCATED],
             reject_count[ERR_UNKNOWN], reject_count[ERR_OVERRUN]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pupd_pkg.sv
sv/pupd_cfg.sv
sv/pupd_parser.sv
sv/pupd_fifo.sv
sv/priority_update_frame_parser_core.sv
verif/tb_top.sv
